[design/pes_pkg.sv]
// periodic event scheduler: shared types and constants
// no dependencies; imported by the scheduler top level
`default_nettype none

package pes_pkg;

    // field widths fixed by the item format
    localparam int PERIOD_W = 31;
    localparam int ID_W     = 8;

    // largest period value, marks an unusable period
    localparam logic [PERIOD_W-1:0] INT_MAX   = 31'h7FFF_FFFF;
    // tick count value after which the count wraps to zero
    localparam logic [PERIOD_W-1:0] TICK_LAST = 31'h7FFF_FFFE;
    // first bit position of the remainder walk
    localparam logic [4:0] DIV_FIRST = 5'd30;

    // input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FIRED    = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_FULL     = 2'd2,
        KIND_BAD      = 2'd3
    } kind_t;

    // one table entry as held in the table memory
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remain;   // tick count modulo period
        logic [ID_W-1:0]     id;
    } entry_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INS_RD,
        ST_INS_CHK,
        ST_RESP,
        ST_TK_RD,
        ST_TK_CHK,
        ST_TK_END
    } state_t;

endpackage : pes_pkg

`default_nettype wire

[design/periodic_event_scheduler.sv]
// periodic event scheduler top level: sequencer, remainder unit, output register
// depends on pes_pkg and pes_ram
//
// channel   direction  transfer when            payload
// input     in         in_valid && !in_stall    op, period, event_id
// output    out        out_valid && !out_stall  kind, fired_id, last
//
// Tick: one table memory read and one write-back per used entry, then the tick
// count advances; the output side may stall the scan.
// Add: a rejected add goes straight to the response; otherwise the remainder of
// the tick count is formed bit-serially, entries with longer periods move up one
// place, the new entry is placed, and the status is sent, subject to output stalls.
// Reset clears the state, counters and valid flags only; the table needs no
// clearing pass since entries at or above the used count are never read.
// Each entry keeps the tick count modulo its period, so a tick needs no divider.
`default_nettype none

module periodic_event_scheduler
    import pes_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                op,
    input  wire logic [PERIOD_W-1:0] period,
    input  wire logic [ID_W-1:0]     event_id,
    // output channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [1:0]          kind,
    output logic      [ID_W-1:0]     fired_id,
    output logic                     last
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = $bits(entry_t);

    state_t              state_reg, state_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [4:0]          div_cnt_reg, div_cnt_next;
    kind_t               resp_kind_reg, resp_kind_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;

    // table memory port signals
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_entry, rd_entry;
    logic [EW-1:0] rd_bits;

    // decoded conditions
    logic                in_xfer;
    logic                out_free;
    logic                add_bad, add_full;
    logic                fire, tk_hold, scan_last;
    logic [CW-1:0]       pos_dec;
    logic [PERIOD_W:0]   div_shift, div_diff;
    logic [PERIOD_W-1:0] rem_inc, rem_upd;
    entry_t              new_entry;

    pes_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    // handshake and status decode
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign add_bad   = (period == '0) || (period == INT_MAX);
    assign add_full  = (used_reg == CW'(SLOTS));
    assign pos_dec   = pos_reg - CW'(1);
    assign scan_last = ((pos_reg + CW'(1)) == used_reg);

    // one restoring step of tick count modulo period
    assign div_shift = {rem_reg, tick_reg[div_cnt_reg]};
    assign div_diff  = div_shift - {1'b0, per_reg};

    // fire check and remainder update for the entry being scanned
    assign fire    = (tick_reg != '0) && (rd_entry.remain == '0);
    assign tk_hold = fire && pend_valid_reg && !out_free;
    assign rem_inc = rd_entry.remain + PERIOD_W'(1);
    assign rem_upd = ((tick_reg == TICK_LAST) || (rem_inc == rd_entry.period))
                     ? '0 : rem_inc;

    assign new_entry = '{period: per_reg, remain: rem_reg, id: id_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (op == OP_ADD)
                    begin
                        state_next = (add_bad || add_full) ? ST_RESP : ST_DIV;
                    end
                    else
                    begin
                        state_next = (used_reg == '0) ? ST_TK_END : ST_TK_RD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_RD:
            begin
                state_next = (pos_reg == '0) ? ST_RESP : ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                state_next = (rd_entry.period > per_reg) ? ST_INS_RD : ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TK_RD:
            begin
                state_next = ST_TK_CHK;
            end
            ST_TK_CHK:
            begin
                if (!tk_hold)
                begin
                    state_next = scan_last ? ST_TK_END : ST_TK_RD;
                end
            end
            ST_TK_END:
            begin
                if (!(pend_valid_reg && !out_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, table accesses and output loading
    always_comb
    begin
        tick_next       = tick_reg;
        used_next       = used_reg;
        pos_next        = pos_reg;
        per_next        = per_reg;
        id_next         = id_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        resp_kind_next  = resp_kind_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_addr         = pos_reg[AW-1:0];
        wr_entry        = new_entry;
        rd_en           = 1'b0;
        rd_addr         = pos_reg[AW-1:0];

        unique case (state_reg)
            // take the item and classify it
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    per_next        = period;
                    id_next         = event_id;
                    rem_next        = '0;
                    div_cnt_next    = DIV_FIRST;
                    pend_valid_next = 1'b0;
                    pos_next        = (op == OP_ADD) ? used_reg : '0;
                    if (add_bad)
                    begin
                        resp_kind_next = KIND_BAD;
                    end
                    else if (add_full)
                    begin
                        resp_kind_next = KIND_FULL;
                    end
                    else
                    begin
                        resp_kind_next = KIND_ACCEPTED;
                    end
                end
            end
            // bit-serial remainder, most significant bit first
            ST_DIV:
            begin
                rem_next     = (div_shift >= {1'b0, per_reg}) ? div_diff[PERIOD_W-1:0]
                                                              : div_shift[PERIOD_W-1:0];
                div_cnt_next = div_cnt_reg - 5'd1;
            end
            // walk down from the top of the table
            ST_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en     = 1'b1;
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = pos_dec[AW-1:0];
                end
            end
            // move a longer period up one place, or drop the new event in
            ST_INS_CHK:
            begin
                wr_en = 1'b1;
                if (rd_entry.period > per_reg)
                begin
                    wr_entry = rd_entry;
                    pos_next = pos_dec;
                end
                else
                begin
                    used_next = used_reg + CW'(1);
                end
            end
            // add status transfer
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = resp_kind_reg;
                    out_id_next    = id_reg;
                    out_last_next  = 1'b1;
                end
            end
            ST_TK_RD:
            begin
                rd_en = 1'b1;
            end
            // check entry, write back remainder, keep one fired id in hand
            ST_TK_CHK:
            begin
                if (!tk_hold)
                begin
                    wr_en    = 1'b1;
                    wr_entry = '{period: rd_entry.period, remain: rem_upd, id: rd_entry.id};
                    pos_next = pos_reg + CW'(1);
                    if (fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_FIRED;
                            out_id_next    = pend_id_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_entry.id;
                    end
                end
            end
            // final fired transfer, then advance the tick count
            ST_TK_END:
            begin
                if (!(pend_valid_reg && !out_free))
                begin
                    tick_next = (tick_reg == TICK_LAST) ? '0 : tick_reg + PERIOD_W'(1);
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_FIRED;
                        out_id_next     = pend_id_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        per_reg       <= per_next;
        id_reg        <= id_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        resp_kind_reg <= resp_kind_next;
        pend_id_reg   <= pend_id_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    // output ports
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign fired_id  = out_id_reg;
    assign last      = out_last_reg;

endmodule : periodic_event_scheduler

`default_nettype wire

[design/pes_ram.sv]
// generic simple dual-port synchronous RAM (one write, one read port) with registered read data
// no dependencies; used for the scheduler's event table
`default_nettype none

module pes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : pes_ram

`default_nettype wire
